@@ src/temperature_to_seven_segment_frames_defines.svh @@
// ----------------------------------------------------------------------------
// temperature_to_seven_segment_frames_defines.svh
// Assertion macros shared by the temperature display block.
// ----------------------------------------------------------------------------
`ifndef TEMPERATURE_TO_SEVEN_SEGMENT_FRAMES_DEFINES_SVH
`define TEMPERATURE_TO_SEVEN_SEGMENT_FRAMES_DEFINES_SVH

// Checked at every edge outside reset.
`define TSSF_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("tssf assertion failed");

// Checked at every edge, reset included.
`define TSSF_ASSERT_NORST(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("tssf assertion failed during reset");

`endif

@@ src/tssf_pkg.sv @@
// ----------------------------------------------------------------------------
// tssf_pkg
// Types, widths and the segment table of the temperature display block.
// ----------------------------------------------------------------------------
`default_nettype none

package tssf_pkg;

   // Reading width and the display side.
   localparam int RAW_WIDTH           = 16;
   localparam int SEG_WIDTH           = 8;
   localparam int POS_WIDTH           = 3;
   localparam int DIGIT_WIDTH         = 4;
   localparam int DIGIT_COUNT_DEFAULT = 8;

   // Magnitude takes one more bit; hundredths of a degree fit in 18 bits.
   localparam int MAG_WIDTH   = RAW_WIDTH + 1;
   localparam int SUM_WIDTH   = MAG_WIDTH + 5;
   localparam int VALUE_WIDTH = SUM_WIDTH - 2;

   // Divide by ten: ceil(2^21 / 10), exact for every value below 2^18.
   localparam int                   RECIP_SHIFT = 21;
   localparam int                   RECIP_WIDTH = 18;
   localparam logic [RECIP_WIDTH-1:0] RECIP_TEN = 18'd209716;
   localparam int                   PROD_WIDTH  = VALUE_WIDTH + RECIP_WIDTH;

   // What travels from one digit cell to the next.
   typedef struct packed {
      logic                   valid;
      logic [VALUE_WIDTH-1:0] value;
   } cell_type;

   // Seven-segment pattern, bit 0 = segment a.
   function automatic logic [SEG_WIDTH-1:0] seg_code(input logic [DIGIT_WIDTH-1:0] digit);
      logic [SEG_WIDTH-1:0] code;
      case (digit)
         4'd0:    code = 8'h3f;
         4'd1:    code = 8'h06;
         4'd2:    code = 8'h5b;
         4'd3:    code = 8'h4f;
         4'd4:    code = 8'h66;
         4'd5:    code = 8'h6d;
         4'd6:    code = 8'h7d;
         4'd7:    code = 8'h07;
         4'd8:    code = 8'h7f;
         4'd9:    code = 8'h6f;
         default: code = 8'h00;
      endcase
      return code;
   endfunction

endpackage

`default_nettype wire

@@ src/tssf_scale.sv @@
// ----------------------------------------------------------------------------
// tssf_scale
// Input stage: magnitude of the reading and scaling to hundredths of a degree.
// ----------------------------------------------------------------------------
`default_nettype none

module tssf_scale (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output      logic                             req_stall,
   input  wire logic signed [tssf_pkg::RAW_WIDTH-1:0] req_raw_temperature,
   input  wire logic                             take,
   output      tssf_pkg::cell_type               front
);
   import tssf_pkg::*;

   logic                   valid_ff, valid_in;
   logic [VALUE_WIDTH-1:0] value_ff, value_in;
   logic [MAG_WIDTH-1:0]   mag;
   logic [SUM_WIDTH-1:0]   sum;
   logic                   accept;

   // Magnitude as two's complement; the most negative reading gives 32768.
   always_comb begin
      if (req_raw_temperature[RAW_WIDTH-1]) begin
         mag = MAG_WIDTH'(17'h10000) - {1'b0, req_raw_temperature};
      end else begin
         mag = {1'b0, req_raw_temperature};
      end
   end

   // round(m * 6.25) = (25m + 2) >> 2
   assign sum = SUM_WIDTH'({mag, 4'b0}) + SUM_WIDTH'({mag, 3'b0}) + SUM_WIDTH'(mag)
              + SUM_WIDTH'(2);

   // Holding register; frees up in the cycle the chain takes it
   assign req_stall = valid_ff & ~take;
   assign accept    = req_valid & ~req_stall;

   always_comb begin
      valid_in = valid_ff;
      value_in = value_ff;
      if (accept) begin
         valid_in = 1'b1;
         value_in = sum[SUM_WIDTH-1:2];
      end else if (take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      value_ff <= value_in;
   end

   assign front.valid = valid_ff;
   assign front.value = value_ff;

endmodule

`default_nettype wire

@@ src/tssf_cell.sv @@
// ----------------------------------------------------------------------------
// tssf_cell
// One digit cell: holds a value, splits off its lowest decimal digit and
// hands the quotient to the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module tssf_cell (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                advance,
   input  wire tssf_pkg::cell_type                  cell_in,
   output      tssf_pkg::cell_type                  cell_out,
   output      logic [tssf_pkg::DIGIT_WIDTH-1:0]    digit
);
   import tssf_pkg::*;

   logic                   valid_ff, valid_in;
   logic [VALUE_WIDTH-1:0] value_ff, value_in;
   logic [PROD_WIDTH-1:0]  product;
   logic [VALUE_WIDTH-1:0] quotient;
   logic [VALUE_WIDTH-1:0] remainder;

   // Shift in from the left neighbor on every advance
   assign valid_in = advance ? cell_in.valid : valid_ff;
   assign value_in = advance ? cell_in.value : value_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      value_ff <= value_in;
   end

   // Divide by ten through the reciprocal
   assign product   = PROD_WIDTH'(value_ff) * PROD_WIDTH'(RECIP_TEN);
   assign quotient  = VALUE_WIDTH'(product >> RECIP_SHIFT);
   assign remainder = value_ff - ((quotient << 3) + (quotient << 1));
   assign digit     = remainder[DIGIT_WIDTH-1:0];

   assign cell_out.valid = valid_ff;
   assign cell_out.value = quotient;

endmodule

`default_nettype wire

@@ src/temperature_to_seven_segment_frames.sv @@
// ----------------------------------------------------------------------------
// temperature_to_seven_segment_frames
// Raw sensor reading to one seven-segment beat per decimal digit.
// ----------------------------------------------------------------------------
// A reading (two's complement, 1/16 degree) is taken as its magnitude,
// scaled to hundredths of a degree with rounding, and sent out as
// DIGIT_COUNT beats, least significant digit first, each with the segment
// pattern, the digit position and a last flag on the final digit. The sign
// is not shown and upper zeros are not blanked. The reading walks down a
// chain of DIGIT_COUNT digit cells, one cell a cycle unless the result
// register stalls, and each cell delivers its digit to the single result
// register. The next reading enters the chain in the cycle the last digit
// of the previous one leaves; no new one is taken before. From accept a
// reading passes the holding register, the first cell, then the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module temperature_to_seven_segment_frames #(
   parameter int DIGIT_COUNT = tssf_pkg::DIGIT_COUNT_DEFAULT
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output      logic                                  req_stall,
   input  wire logic signed [tssf_pkg::RAW_WIDTH-1:0] req_raw_temperature,
   output      logic                                  rsp_valid,
   input  wire logic                                  rsp_stall,
   output      logic [tssf_pkg::SEG_WIDTH-1:0]        rsp_segment_code,
   output      logic [tssf_pkg::POS_WIDTH-1:0]        rsp_digit_position,
   output      logic                                  rsp_last_digit
);
   import tssf_pkg::*;

`include "temperature_to_seven_segment_frames_defines.svh"

   localparam logic [POS_WIDTH-1:0] LAST_POS = POS_WIDTH'(DIGIT_COUNT - 1);

   cell_type               front;
   cell_type               chain_in  [DIGIT_COUNT];
   cell_type               chain_out [DIGIT_COUNT];
   logic [DIGIT_WIDTH-1:0] digit     [DIGIT_COUNT];
   logic [DIGIT_COUNT-1:0] cell_valid;
   logic                   advance;
   logic                   chain_free;
   logic                   take;
   logic                   any_valid;
   logic [DIGIT_WIDTH-1:0] sel_digit;
   logic [POS_WIDTH-1:0]   sel_pos;
   logic                   sel_last;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [SEG_WIDTH-1:0]   seg_ff, seg_in;
   logic [POS_WIDTH-1:0]   pos_ff, pos_in;
   logic                   last_ff, last_in;

   // Chain moves whenever the result register can take a beat
   assign advance    = ~rsp_valid_ff | ~rsp_stall;
   // One reading in the chain at a time; the last cell is leaving
   assign chain_free = ~|cell_valid[DIGIT_COUNT-2:0];
   assign take       = advance & chain_free;

   tssf_scale u_scale (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_raw_temperature (req_raw_temperature),
      .take                (take),
      .front               (front)
   );

   // Digit chain
   assign chain_in[0].valid = front.valid & chain_free;
   assign chain_in[0].value = front.value;

   for (genvar k = 0; k < DIGIT_COUNT; k++) begin : g_cell
      if (k > 0) begin : g_link
         assign chain_in[k] = chain_out[k-1];
      end
      tssf_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .advance  (advance),
         .cell_in  (chain_in[k]),
         .cell_out (chain_out[k]),
         .digit    (digit[k])
      );
      assign cell_valid[k] = chain_out[k].valid;
   end

   // Pick the digit of the occupied cell
   always_comb begin
      sel_digit = '0;
      sel_pos   = '0;
      sel_last  = 1'b0;
      for (int k = 0; k < DIGIT_COUNT; k++) begin
         if (cell_valid[k]) begin
            sel_digit = digit[k];
            sel_pos   = POS_WIDTH'(k);
            sel_last  = (k == DIGIT_COUNT - 1);
         end
      end
   end
   assign any_valid = |cell_valid;

   // Result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      seg_in       = seg_ff;
      pos_in       = pos_ff;
      last_in      = last_ff;
      if (advance) begin
         rsp_valid_in = any_valid;
         seg_in       = seg_code(sel_digit);
         pos_in       = sel_pos;
         last_in      = sel_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      seg_ff  <= seg_in;
      pos_ff  <= pos_in;
      last_ff <= last_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_segment_code   = seg_ff;
   assign rsp_digit_position = pos_ff;
   assign rsp_last_digit     = last_ff;

   // Checks
   `TSSF_ASSERT(a_one_reading, clock, reset, $onehot0(cell_valid))
   `TSSF_ASSERT(a_digit_range, clock, reset, any_valid |-> (sel_digit <= 4'd9))
   `TSSF_ASSERT(a_last_pos, clock, reset, rsp_valid_ff && last_ff |-> pos_ff == LAST_POS)
   `TSSF_ASSERT_NORST(a_reset_idle, clock, reset |=> !rsp_valid)

endmodule

`default_nettype wire
